>>> rtl/software_timer_table_top_macros.svh
// Assertion macros for the software timer table checker.
`ifndef SOFTWARE_TIMER_TABLE_TOP_MACROS_SVH
`define SOFTWARE_TIMER_TABLE_TOP_MACROS_SVH
// Implication checked on the same edge.
`define STT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timer table check failed");
// Implication checked on the following edge.
`define STT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer table check failed");
`endif

>>> rtl/stt_pkg.sv
// Package for the software timer table: types, codes and defaults.
package stt_pkg;
  localparam int STT_NUM_TIMERS = 16;

  localparam logic [1:0] FUNC_ONESHOT = 2'd0;
  localparam logic [1:0] FUNC_RELOAD  = 2'd1;
  localparam logic [1:0] FUNC_STOP    = 2'd2;
  localparam logic [1:0] FUNC_TICK    = 2'd3;

  localparam logic [1:0] KIND_STATUS   = 2'd0;
  localparam logic [1:0] KIND_FIRED    = 2'd1;
  localparam logic [1:0] KIND_TICKDONE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOSLOT   = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_ZEROMASK = 2'd3;

  typedef struct packed {
    logic [31:0] timeout;
    logic [31:0] reload;
    logic [7:0]  task_id;
    logic [15:0] event_mask;
  } cell_t;

  typedef struct packed {
    logic en;   // cell takes a new value
    logic sel;  // 1: write data, 0: neighbour's value
  } cell_ctl_t;

  typedef enum logic [1:0] {S_IDLE, S_TICK, S_FIND, S_DONE} state_t;
endpackage

>>> rtl/stt_cell.sv
// One timer cell of the service chain: holds one timer, shifts from its neighbour.
module stt_cell
  import stt_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  cell_t     next_d,
  input  cell_t     wr_d,
  output cell_t     q
);
  cell_t q_r;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      q_r <= ctl.sel ? wr_d : next_d;
    end
  end

  assign q = q_r;
endmodule

>>> rtl/software_timer_table_top.sv
// Top level of the software timer table: control sequencer and chain of timer cells.
//
//  channel | direction | handshake      | payload
//  in_     | input     | valid / stall  | func, task_id, event_mask, timeout_ms
//  out_    | output    | valid / stall  | kind, status, fired_task, fired_event,
//          |           |                | clock_ms, ticking, last
//  cfg_    | input     | valid / ready  | data (tick_ms)
//
// An item walks once over the n active timers of the chain; the rotation of
// the cell chain brings one timer to the head cell per cycle, except while
// an expired timer waits on a stalled result side. A start or stop with a
// zero event mask, or an item on an empty chain, skips the walk.
// Reset is synchronous and active low; it empties the chain at once.
// The input is stalled while an item is in progress; results wait in a
// single output register.
//
// Active timers sit in the chain in service order, cell 0 being the head.
// Each step the head timer is examined and the chain shifts by one; a timer
// that survives is written back behind the last active cell, so after one
// full pass the order is restored. A freed timer simply drops out.
module software_timer_table_top
  import stt_pkg::*;
#(
  parameter int NUM_TIMERS = STT_NUM_TIMERS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_task_id,
  input  logic [15:0] in_event_mask,
  input  logic [31:0] in_timeout_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [1:0]  out_status,
  output logic [7:0]  out_fired_task,
  output logic [15:0] out_fired_event,
  output logic [31:0] out_clock_ms,
  output logic        out_ticking,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  cfg_data
);
  localparam int CW = $clog2(NUM_TIMERS + 1);

  state_t      state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, steps_r, steps_nxt;
  logic        found_r, found_nxt;
  logic [1:0]  func_r;
  logic [7:0]  task_r;
  logic [15:0] ev_r;
  logic [31:0] tmo_r;
  logic [31:0] clock_r, clock_nxt;
  logic        ten_r, ten_nxt;
  logic [9:0]  tick_r;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  kind_r, kind_nxt, status_r, status_nxt;
  logic [7:0]  ftask_r, ftask_nxt;
  logic [15:0] fev_r, fev_nxt;
  logic [31:0] oclk_r, oclk_nxt;
  logic        oten_r, oten_nxt, last_r, last_nxt;

  cell_t       q [NUM_TIMERS];
  cell_t       wr_d;
  cell_t       head;
  logic        shift_en, surv, app_en;
  logic        out_can, accept;
  logic        match;
  logic [31:0] dec;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_can   = !out_valid_r || !out_stall;
  assign head      = q[0];
  assign match     = !found_r && head.task_id == task_r && head.event_mask == ev_r;
  assign dec       = (head.timeout <= {22'd0, tick_r}) ? 32'd0
                                                       : head.timeout - {22'd0, tick_r};

  // Cell chain; the last cell shifts in nothing of use.
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    cell_ctl_t ctl;
    cell_t     nd;
    if (i == NUM_TIMERS - 1) begin : g_end
      assign nd = '0;
    end else begin : g_mid
      assign nd = q[i+1];
    end
    assign ctl.en  = shift_en || (app_en && cnt_r == CW'(i));
    assign ctl.sel = shift_en ? (surv && cnt_r == CW'(i + 1)) : 1'b1;
    stt_cell u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .next_d (nd),
      .wr_d   (wr_d),
      .q      (q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      steps_r     <= '0;
      found_r     <= 1'b0;
      clock_r     <= '0;
      ten_r       <= 1'b0;
      tick_r      <= 10'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      steps_r     <= steps_nxt;
      found_r     <= found_nxt;
      clock_r     <= clock_nxt;
      ten_r       <= ten_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        tick_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_func;
      task_r <= in_task_id;
      ev_r   <= in_event_mask;
      tmo_r  <= in_timeout_ms;
    end
    kind_r   <= kind_nxt;
    status_r <= status_nxt;
    ftask_r  <= ftask_nxt;
    fev_r    <= fev_nxt;
    oclk_r   <= oclk_nxt;
    oten_r   <= oten_nxt;
    last_r   <= last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    steps_nxt     = steps_r;
    found_nxt     = found_r;
    clock_nxt     = clock_r;
    ten_nxt       = ten_r;
    shift_en      = 1'b0;
    surv          = 1'b0;
    app_en        = 1'b0;
    wr_d          = head;
    out_valid_nxt = out_valid_r && out_stall;
    kind_nxt      = kind_r;
    status_nxt    = status_r;
    ftask_nxt     = ftask_r;
    fev_nxt       = fev_r;
    oclk_nxt      = oclk_r;
    oten_nxt      = oten_r;
    last_nxt      = last_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          steps_nxt = cnt_r;
          found_nxt = 1'b0;
          if (in_func == FUNC_TICK) begin
            clock_nxt = clock_r + {22'd0, tick_r};
            state_nxt = (cnt_r == '0) ? S_DONE : S_TICK;
          end else if (in_event_mask == 16'd0 || cnt_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_FIND;
          end
        end
      end
      S_TICK: begin
        if (dec != 32'd0 || out_can) begin
          shift_en  = 1'b1;
          steps_nxt = steps_r - CW'(1);
          if (dec == 32'd0) begin
            out_valid_nxt = 1'b1;
            kind_nxt   = KIND_FIRED;
            status_nxt = ST_OK;
            ftask_nxt  = head.task_id;
            fev_nxt    = head.event_mask;
            oclk_nxt   = clock_r;
            oten_nxt   = ten_r;
            last_nxt   = 1'b0;
            surv       = (head.reload != 32'd0);
            wr_d.timeout = head.reload;
          end else begin
            surv         = 1'b1;
            wr_d.timeout = dec;
          end
          if (!surv) begin
            cnt_nxt = cnt_r - CW'(1);
          end
          if (steps_r == CW'(1)) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_FIND: begin
        shift_en  = 1'b1;
        steps_nxt = steps_r - CW'(1);
        found_nxt = found_r || match;
        if (func_r == FUNC_STOP) begin
          surv = !match;
          if (match) begin
            cnt_nxt = cnt_r - CW'(1);
          end
        end else begin
          surv = 1'b1;
          if (match) begin
            wr_d.timeout = tmo_r;
            if (func_r == FUNC_RELOAD) begin
              wr_d.reload = tmo_r;
            end
          end
        end
        if (steps_r == CW'(1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_can) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_STATUS;
          status_nxt    = ST_OK;
          ftask_nxt     = 8'd0;
          fev_nxt       = 16'd0;
          last_nxt      = 1'b1;
          wr_d.timeout    = tmo_r;
          wr_d.reload     = (func_r == FUNC_RELOAD) ? tmo_r : 32'd0;
          wr_d.task_id    = task_r;
          wr_d.event_mask = ev_r;
          if (func_r == FUNC_TICK) begin
            kind_nxt = KIND_TICKDONE;
          end else if (ev_r == 16'd0) begin
            status_nxt = ST_ZEROMASK;
          end else if (func_r == FUNC_STOP) begin
            status_nxt = found_r ? ST_OK : ST_NOTFOUND;
          end else if (found_r) begin
            ten_nxt = 1'b1;
          end else if (cnt_r == CW'(NUM_TIMERS)) begin
            status_nxt = ST_NOSLOT;
          end else begin
            app_en  = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
            ten_nxt = 1'b1;
          end
          oclk_nxt = clock_r;
          oten_nxt = ten_nxt;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_status      = status_r;
  assign out_fired_task  = ftask_r;
  assign out_fired_event = fev_r;
  assign out_clock_ms    = oclk_r;
  assign out_ticking     = oten_r;
  assign out_last        = last_r;
endmodule

>>> rtl/stt_checker.sv
// Port-level checker for the software timer table and its bind.
`include "software_timer_table_top_macros.svh"
module stt_checker
  import stt_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_kind,
  input logic [1:0]  out_status,
  input logic [7:0]  out_fired_task,
  input logic [15:0] out_fired_event,
  input logic        out_last
);
  `STT_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
  `STT_ASSERT_IMP(a_status_last, out_valid && out_kind == KIND_STATUS, out_last)
  `STT_ASSERT_IMP(a_fired_not_last, out_valid && out_kind == KIND_FIRED, !out_last && out_status == ST_OK)
  `STT_ASSERT_IMP(a_tickdone, out_valid && out_kind == KIND_TICKDONE, out_last && out_fired_task == 8'd0 && out_fired_event == 16'd0)
endmodule

bind software_timer_table_top stt_checker u_stt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_kind        (out_kind),
  .out_status      (out_status),
  .out_fired_task  (out_fired_task),
  .out_fired_event (out_fired_event),
  .out_last        (out_last)
);

>>> verif/tb_software_timer_table_top.sv
// Self-checking testbench for the software timer table top level.
module tb_software_timer_table_top;
  import stt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = STT_NUM_TIMERS;
  // Cycles with no accepted item or result before the run is declared hung.
  localparam int STALL_LIMIT = 6000;

  // One result item as the block presents it.
  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [7:0]  fired_task;
    logic [15:0] fired_event;
    logic [31:0] clock_ms;
    logic        ticking;
    logic        last;
  } timer_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_func = FUNC_TICK;
  logic [7:0]  in_task_id = '0;
  logic [15:0] in_event_mask = '0;
  logic [31:0] in_timeout_ms = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [1:0]  out_status;
  logic [7:0]  out_fired_task;
  logic [15:0] out_fired_event;
  logic [31:0] out_clock_ms;
  logic        out_ticking;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [9:0]  cfg_data = '0;

  software_timer_table_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_func(in_func), .in_task_id(in_task_id),
    .in_event_mask(in_event_mask), .in_timeout_ms(in_timeout_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_kind(out_kind), .out_status(out_status),
    .out_fired_task(out_fired_task), .out_fired_event(out_fired_event),
    .out_clock_ms(out_clock_ms), .out_ticking(out_ticking), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the timer table, kept in step with every accepted item.
  logic [31:0]   sh_timeout [NSLOT];
  logic [31:0]   sh_reload  [NSLOT];
  logic [7:0]    sh_task    [NSLOT];
  logic [15:0]   sh_event   [NSLOT];
  int            service_order[$];   // active slots, head of the list first
  logic [31:0]   sh_clock;
  logic          sh_ticking;
  logic [9:0]    sh_tick_ms;
  timer_result_t pending_results[$]; // results still to come, oldest first

  // Idling controls, changed by the test tasks between phases, and the run counters.
  int  gap_pct = 0;
  int  stall_pct = 0;
  int  hold_requests = 0;
  int  hold_seen = 0;
  int  hold_left = 0;
  int  errors = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  fired_seen = 0;
  int  idle_cycles = 0;

  // Key pools, filled with random values so that every bit of the task and
  // event fields is exercised while starts and stops still hit live timers.
  logic [7:0]  task_pool  [6];
  logic [15:0] event_pool [6];

  function automatic timer_result_t make_result(logic [1:0] kind, logic [1:0] status,
                                                logic [7:0] tsk, logic [15:0] ev,
                                                logic last);
    timer_result_t r;
    r.kind = kind;
    r.status = status;
    r.fired_task = tsk;
    r.fired_event = ev;
    r.clock_ms = sh_clock;
    r.ticking = sh_ticking;
    r.last = last;
    return r;
  endfunction

  // Returns the position in the service order of the timer with this key, or -1.
  function automatic int find_key(logic [7:0] tsk, logic [15:0] ev);
    foreach (service_order[i])
      if (sh_event[service_order[i]] == ev && sh_task[service_order[i]] == tsk) return i;
    return -1;
  endfunction

  function automatic void free_slot(int s);
    sh_event[s] = '0;
    sh_task[s] = '0;
    sh_reload[s] = '0;
  endfunction

  // Works out the results of one accepted item and updates the shadow table.
  function automatic void predict_timer_item(logic [1:0] func, logic [7:0] tsk,
                                             logic [15:0] ev, logic [31:0] tmo);
    int pos;
    int s;
    int kept[$];
    logic [31:0] t;
    logic [1:0] st;
    if (func == FUNC_TICK) begin
      sh_clock = sh_clock + 32'(sh_tick_ms);
      foreach (service_order[i]) begin
        s = service_order[i];
        t = (sh_timeout[s] <= 32'(sh_tick_ms)) ? 32'd0 : sh_timeout[s] - 32'(sh_tick_ms);
        sh_timeout[s] = t;
        if (t == 32'd0) begin
          pending_results.push_back(make_result(KIND_FIRED, ST_OK, sh_task[s], sh_event[s],
                                                1'b0));
          if (sh_reload[s] != 32'd0) begin
            sh_timeout[s] = sh_reload[s];
            kept.push_back(s);
          end else begin
            free_slot(s);
          end
        end else begin
          kept.push_back(s);
        end
      end
      service_order = kept;
      pending_results.push_back(make_result(KIND_TICKDONE, ST_OK, '0, '0, 1'b1));
      return;
    end
    pos = find_key(tsk, ev);
    if (ev == 16'd0) begin
      st = ST_ZEROMASK;
    end else if (func == FUNC_STOP) begin
      if (pos < 0) begin
        st = ST_NOTFOUND;
      end else begin
        free_slot(service_order[pos]);
        service_order.delete(pos);
        st = ST_OK;
      end
    end else begin
      st = ST_OK;
      if (pos >= 0) begin
        s = service_order[pos];
      end else begin
        s = -1;
        for (int i = 0; i < NSLOT; i++)
          if (s < 0 && sh_event[i] == 16'd0) s = i;
        if (s >= 0) begin
          sh_task[s] = tsk;
          sh_event[s] = ev;
          service_order.push_back(s);
        end else begin
          st = ST_NOSLOT;
        end
      end
      if (s >= 0) begin
        sh_timeout[s] = tmo;
        if (func == FUNC_RELOAD) sh_reload[s] = tmo;
        sh_ticking = 1'b1;
      end
    end
    pending_results.push_back(make_result(KIND_STATUS, st, '0, '0, 1'b1));
  endfunction

  // Offers one item and waits until the block takes it; called just after an edge.
  task automatic send_timer_item(logic [1:0] func, logic [7:0] tsk, logic [15:0] ev,
                                 logic [31:0] tmo);
    int gap;
    in_valid <= 1'b1;
    in_func <= func;
    in_task_id <= tsk;
    in_event_mask <= ev;
    in_timeout_ms <= tmo;
    do @(posedge clk); while (in_stall);
    predict_timer_item(func, tsk, ev, tmo);
    items_sent++;
    gap = 0;
    while ($urandom_range(0, 99) < gap_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Lets every expected result drain, then a margin for any walk still running.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Writes tick_ms while the block is idle.
  task automatic write_tick_ms(logic [9:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    sh_tick_ms = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_timeout();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return $urandom_range(0, 5 * (32'(sh_tick_ms) + 1));
  endfunction

  // One random item: mostly starts, stops and ticks on live keys.
  task automatic send_random_item();
    int sel;
    logic [7:0] tsk;
    logic [15:0] ev;
    logic [1:0] func;
    sel = $urandom_range(0, 99);
    tsk = task_pool[$urandom_range(0, 5)];
    ev = event_pool[$urandom_range(0, 5)];
    if ($urandom_range(0, 19) == 0) ev = '0;
    if ($urandom_range(0, 19) == 0) tsk = 8'($urandom_range(0, 255));
    if (sel < 25) func = FUNC_ONESHOT;
    else if (sel < 45) func = FUNC_RELOAD;
    else if (sel < 60) func = FUNC_STOP;
    else func = FUNC_TICK;
    send_timer_item(func, tsk, ev, pick_timeout());
  endtask

  // Zero masks, unknown stops, both starts, restarts and zero-timeout reloads.
  task automatic test_basic_operations();
    send_timer_item(FUNC_ONESHOT, 8'd5, 16'h0000, 32'd3);
    send_timer_item(FUNC_STOP, 8'd5, 16'h0000, 32'd0);
    send_timer_item(FUNC_STOP, 8'hFF, 16'hFFFF, 32'd0);
    send_timer_item(FUNC_TICK, 8'd0, 16'd0, 32'd0);
    send_timer_item(FUNC_ONESHOT, 8'hFF, 16'hFFFF, 32'd2);
    send_timer_item(FUNC_RELOAD, 8'h00, 16'h0001, 32'd3);
    send_timer_item(FUNC_RELOAD, 8'hA5, 16'h8000, 32'd0);
    send_timer_item(FUNC_ONESHOT, 8'h00, 16'h0001, 32'd1);
    send_timer_item(FUNC_ONESHOT, 8'h5A, 16'h1234, 32'hFFFF_FFFF);
    repeat (4) send_timer_item(FUNC_TICK, 8'($urandom_range(0, 255)), 16'($urandom()),
                               $urandom());
    send_timer_item(FUNC_STOP, 8'h00, 16'h0001, 32'd0);
    send_timer_item(FUNC_STOP, 8'h5A, 16'h1234, 32'd0);
    send_timer_item(FUNC_TICK, 8'd0, 16'd0, 32'd0);
  endtask

  // Fills every slot, overflows the table, then expires all timers in one tick.
  task automatic test_full_table();
    for (int i = 0; i < NSLOT; i++)
      send_timer_item(FUNC_ONESHOT, 8'(i + 16), 16'(i + 1), 32'd0);
    send_timer_item(FUNC_RELOAD, 8'hEE, 16'hBEEF, 32'd9);
    send_timer_item(FUNC_TICK, 8'd0, 16'd0, 32'd0);
  endtask

  // Unusual tick lengths: zero, a large value and the top of the range.
  task automatic test_tick_lengths();
    write_tick_ms(10'd0);
    send_timer_item(FUNC_RELOAD, 8'h11, 16'h0002, 32'd0);
    send_timer_item(FUNC_ONESHOT, 8'h12, 16'h0004, 32'd5);
    repeat (3) send_timer_item(FUNC_TICK, 8'd0, 16'd0, 32'd0);
    write_tick_ms(10'd1000);
    send_timer_item(FUNC_ONESHOT, 8'h13, 16'h0008, 32'd1500);
    repeat (3) send_timer_item(FUNC_TICK, 8'd0, 16'd0, 32'd0);
    write_tick_ms(10'd1023);
    send_timer_item(FUNC_RELOAD, 8'h14, 16'h0010, 32'd2046);
    repeat (3) send_timer_item(FUNC_TICK, 8'd0, 16'd0, 32'd0);
  endtask

  task automatic test_random_phase(int sender_gap, int receiver_stall, int count,
                                   logic [9:0] tick_len);
    write_tick_ms(tick_len);
    gap_pct = sender_gap;
    stall_pct = receiver_stall;
    repeat (count) send_random_item();
    gap_pct = 0;
    stall_pct = 0;
  endtask

  // The receiver holds off for a long stretch while items keep coming, so the
  // block's single output register fills and its input stalls.
  task automatic test_output_backpressure();
    gap_pct = 0;
    hold_requests++;
    repeat (30) send_random_item();
  endtask

  // Receiver stall: random, or one long hold-off when a test asks for it.
  always @(posedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Each accepted result is checked against the oldest expectation.
  always @(posedge clk) begin
    timer_result_t seen;
    timer_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      seen = '{out_kind, out_status, out_fired_task, out_fired_event, out_clock_ms,
               out_ticking, out_last};
      results_seen++;
      if (out_kind == KIND_FIRED) fired_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: %p", $time, seen);
      end else begin
        want = pending_results.pop_front();
        if (seen.kind != want.kind)
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, seen.kind);
        if (seen.status != want.status)
          $display("%0t: status expected %0d actual %0d", $time, want.status, seen.status);
        if (seen.fired_task != want.fired_task)
          $display("%0t: fired_task expected %0h actual %0h", $time, want.fired_task,
                   seen.fired_task);
        if (seen.fired_event != want.fired_event)
          $display("%0t: fired_event expected %0h actual %0h", $time, want.fired_event,
                   seen.fired_event);
        if (seen.clock_ms != want.clock_ms)
          $display("%0t: clock_ms expected %0d actual %0d", $time, want.clock_ms,
                   seen.clock_ms);
        if (seen.ticking != want.ticking)
          $display("%0t: ticking expected %0b actual %0b", $time, want.ticking, seen.ticking);
        if (seen.last != want.last)
          $display("%0t: last expected %0b actual %0b", $time, want.last, seen.last);
        if (seen != want) errors++;
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      sh_timeout[i] = '0;
      sh_reload[i] = '0;
      sh_task[i] = '0;
      sh_event[i] = '0;
    end
    sh_clock = '0;
    sh_ticking = 1'b0;
    sh_tick_ms = 10'd1;
    foreach (task_pool[i]) task_pool[i] = 8'($urandom_range(0, 255));
    foreach (event_pool[i]) event_pool[i] = 16'($urandom_range(1, 65535));
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_operations();
    test_full_table();
    test_tick_lengths();
    test_random_phase(0, 0, 60, 10'd1);
    test_random_phase(88, 0, 55, 10'd7);
    test_random_phase(0, 88, 55, 10'd1000);
    test_random_phase(33, 33, 55, 10'd3);
    test_output_backpressure();
    drain_results();

    $display("Covered %0d items and %0d results (%0d expiries) across zero, small and",
             items_sent, results_seen, fired_seen);
    $display("large tick lengths, a full table and sender and receiver idling.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, pending_results.size());
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
